@@ hw/rtl/bcl_pkg.sv @@
`default_nettype none

package bcl_pkg;

    localparam int SLOT_COUNT_DEF = 32;

    localparam logic [1:0] ACT_GET     = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_PIN     = 2'd2;
    localparam logic [1:0] ACT_UNPIN   = 2'd3;

    localparam logic [7:0] REF_MAX = 8'hFF;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_SLOT_RD,
        ST_RESPOND
    } state_t;

    // one slot as held in the tag memory
    typedef struct packed {
        logic [7:0]  tag_device;
        logic [31:0] tag_block;
        logic [7:0]  ref_count;
        logic [31:0] last_used;
        logic        data_valid;
    } entry_t;

    typedef struct packed {
        logic [4:0] slot_out;
        logic       hit;
        logic       needs_read;
        logic       no_free;
        logic       underflow;
        logic [7:0] ref_count_out;
    } rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/bcl_if.sv @@
`default_nettype none

interface bcl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  device;
    logic [31:0] block_number;
    logic [4:0]  slot_in;
    logic [31:0] now;

    modport source (
        output valid, action, device, block_number, slot_in, now,
        input  ready
    );
    modport sink (
        input  valid, action, device, block_number, slot_in, now,
        output ready
    );
endinterface

interface bcl_rsp_if;
    logic       valid;
    logic       ready;
    logic [4:0] slot_out;
    logic       hit;
    logic       needs_read;
    logic       no_free;
    logic       underflow;
    logic [7:0] ref_count_out;

    modport source (
        output valid, slot_out, hit, needs_read, no_free, underflow, ref_count_out,
        input  ready
    );
    modport sink (
        input  valid, slot_out, hit, needs_read, no_free, underflow, ref_count_out,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/bcl_slot_mem.sv @@
`default_nettype none

module bcl_slot_mem #(
    parameter int DEPTH = bcl_pkg::SLOT_COUNT_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  bcl_pkg::entry_t     wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output bcl_pkg::entry_t     rd_data
);

    bcl_pkg::entry_t mem_reg [DEPTH];
    bcl_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/bcl_ctrl.sv @@
`default_nettype none

module bcl_ctrl #(
    parameter int SLOT_COUNT = bcl_pkg::SLOT_COUNT_DEF,
    localparam int IDX_W = $clog2(SLOT_COUNT),
    localparam int CNT_W = $clog2(SLOT_COUNT + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    bcl_req_if.sink            req,
    input  logic               out_free,
    output bcl_pkg::rsp_t      result,
    output logic               result_load,
    output logic               mem_wr_en,
    output logic [IDX_W-1:0]   mem_wr_addr,
    output bcl_pkg::entry_t    mem_wr_data,
    output logic               mem_rd_en,
    output logic [IDX_W-1:0]   mem_rd_addr,
    input  bcl_pkg::entry_t    mem_rd_data
);

    bcl_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [1:0]        act_reg;
    logic [7:0]        dev_reg;
    logic [31:0]       blk_reg;
    logic [4:0]        slot_reg;
    logic [31:0]       now_reg;
    logic              oor_reg;

    logic              hit_found_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [7:0]        hit_cnt_reg;
    logic              hit_dv_reg;
    logic [31:0]       hit_last_reg;

    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic [31:0]       free_last_reg;

    logic              accept;
    logic              scan_proc;
    logic [IDX_W-1:0]  scan_idx;
    logic              tag_match;
    logic              free_better;
    logic [IDX_W-1:0]  slot_addr;

    function automatic logic [7:0] sat_inc(input logic [7:0] x);
        return (x == bcl_pkg::REF_MAX) ? x : x + 8'd1;
    endfunction

    assign accept      = req.valid && (state_reg == bcl_pkg::ST_IDLE);
    assign scan_proc   = (state_reg == bcl_pkg::ST_SCAN) && (cnt_reg != '0);
    // read data on the port belongs to the address issued in the previous cycle
    assign scan_idx    = IDX_W'(cnt_reg - CNT_W'(1));
    assign tag_match   = (mem_rd_data.tag_device == dev_reg) &&
                         (mem_rd_data.tag_block == blk_reg);
    // strict compare over ascending slots keeps the lowest slot on a tie
    assign free_better = (mem_rd_data.ref_count == 8'd0) &&
                         (!free_found_reg || (mem_rd_data.last_used < free_last_reg));
    assign slot_addr   = IDX_W'(slot_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bcl_pkg::ST_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg        <= req.action;
            dev_reg        <= req.device;
            blk_reg        <= req.block_number;
            slot_reg       <= req.slot_in;
            now_reg        <= req.now;
            oor_reg        <= (int'(req.slot_in) >= SLOT_COUNT);
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        if (scan_proc)
        begin
            if (tag_match && !hit_found_reg)
            begin
                hit_found_reg <= 1'b1;
                hit_idx_reg   <= scan_idx;
                hit_cnt_reg   <= mem_rd_data.ref_count;
                hit_dv_reg    <= mem_rd_data.data_valid;
                hit_last_reg  <= mem_rd_data.last_used;
            end
            if (free_better)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= scan_idx;
                free_last_reg  <= mem_rd_data.last_used;
            end
        end
    end

    always_comb
    begin
        bcl_pkg::entry_t  e;
        bcl_pkg::rsp_t    r;
        logic [IDX_W-1:0] wa;
        logic             we;
        logic [7:0]       c;

        state_next  = state_reg;
        cnt_next    = cnt_reg;
        req.ready   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        result      = '0;
        result_load = 1'b0;
        e  = mem_rd_data;
        r  = '0;
        wa = slot_addr;
        we = 1'b0;
        c  = 8'd0;

        case (state_reg)
            bcl_pkg::ST_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = IDX_W'(cnt_reg);
                if (cnt_reg == CNT_W'(SLOT_COUNT - 1))
                begin
                    cnt_next   = '0;
                    state_next = bcl_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            bcl_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    cnt_next = '0;
                    if (req.action == bcl_pkg::ACT_GET)
                    begin
                        state_next = bcl_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = bcl_pkg::ST_SLOT_RD;
                    end
                end
            end

            bcl_pkg::ST_SCAN:
            begin
                if (cnt_reg != CNT_W'(SLOT_COUNT))
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = IDX_W'(cnt_reg);
                    cnt_next    = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = bcl_pkg::ST_RESPOND;
                end
            end

            bcl_pkg::ST_SLOT_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = slot_addr;
                state_next  = bcl_pkg::ST_RESPOND;
            end

            bcl_pkg::ST_RESPOND:
            begin
                if (act_reg == bcl_pkg::ACT_GET)
                begin
                    if (hit_found_reg)
                    begin
                        c  = sat_inc(hit_cnt_reg);
                        e  = '{tag_device: dev_reg, tag_block: blk_reg, ref_count: c,
                               last_used: hit_last_reg, data_valid: 1'b1};
                        wa = hit_idx_reg;
                        we = 1'b1;
                        r.slot_out      = 5'(hit_idx_reg);
                        r.hit           = 1'b1;
                        r.needs_read    = !hit_dv_reg;
                        r.ref_count_out = c;
                    end
                    else if (free_found_reg)
                    begin
                        e  = '{tag_device: dev_reg, tag_block: blk_reg, ref_count: 8'd1,
                               last_used: free_last_reg, data_valid: 1'b1};
                        wa = free_idx_reg;
                        we = 1'b1;
                        r.slot_out      = 5'(free_idx_reg);
                        r.needs_read    = 1'b1;
                        r.ref_count_out = 8'd1;
                    end
                    else
                    begin
                        r.no_free = 1'b1;
                    end
                end
                else if (oor_reg)
                begin
                    r.slot_out = slot_reg;
                end
                else if (act_reg == bcl_pkg::ACT_PIN)
                begin
                    c           = sat_inc(mem_rd_data.ref_count);
                    e.ref_count = c;
                    we          = 1'b1;
                    r.slot_out      = slot_reg;
                    r.ref_count_out = c;
                end
                else
                begin
                    r.slot_out = slot_reg;
                    if (mem_rd_data.ref_count == 8'd0)
                    begin
                        r.underflow = 1'b1;
                    end
                    else
                    begin
                        c           = mem_rd_data.ref_count - 8'd1;
                        e.ref_count = c;
                        // only a release down to zero ages the slot
                        if ((act_reg == bcl_pkg::ACT_RELEASE) && (c == 8'd0))
                        begin
                            e.last_used = now_reg;
                        end
                        we = 1'b1;
                        r.ref_count_out = c;
                    end
                end

                result = r;
                if (out_free)
                begin
                    result_load = 1'b1;
                    mem_wr_en   = we;
                    mem_wr_addr = wa;
                    mem_wr_data = e;
                    state_next  = bcl_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bcl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/block_buffer_cache_lru.sv @@
// Get: the tag memory read port scans every slot, one slot a cycle, and the result is
// loaded once the scan is done. Release, pin, unpin: the named slot is read, then the
// result is loaded. Loading waits until the output register is empty or being taken,
// and no request is taken before the load. A finished result waits in an
// output register while the next request is taken. After rst_n rises a clearing pass
// zeroes every slot of the tag memory, during which no request is taken.
`default_nettype none

module block_buffer_cache_lru #(
    parameter int SLOT_COUNT = bcl_pkg::SLOT_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bcl_req_if.sink    req,
    bcl_rsp_if.source  rsp
);

    localparam int IDX_W = $clog2(SLOT_COUNT);

    logic              out_valid_reg;
    bcl_pkg::rsp_t     rsp_reg;
    logic              out_free;
    bcl_pkg::rsp_t     result;
    logic              result_load;

    logic              mem_wr_en;
    logic [IDX_W-1:0]  mem_wr_addr;
    bcl_pkg::entry_t   mem_wr_data;
    logic              mem_rd_en;
    logic [IDX_W-1:0]  mem_rd_addr;
    bcl_pkg::entry_t   mem_rd_data;

    assign out_free = !out_valid_reg || rsp.ready;

    bcl_ctrl #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .out_free    (out_free),
        .result      (result),
        .result_load (result_load),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    bcl_slot_mem #(
        .DEPTH (SLOT_COUNT)
    ) u_slot_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.slot_out      = rsp_reg.slot_out;
    assign rsp.hit           = rsp_reg.hit;
    assign rsp.needs_read    = rsp_reg.needs_read;
    assign rsp.no_free       = rsp_reg.no_free;
    assign rsp.underflow     = rsp_reg.underflow;
    assign rsp.ref_count_out = rsp_reg.ref_count_out;

endmodule

`default_nettype wire

@@ hw/rtl/bcl_checker.sv @@
`default_nettype none

module bcl_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_valid,
    input wire logic       req_ready,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [4:0] slot_out,
    input wire logic       hit,
    input wire logic       needs_read,
    input wire logic       no_free,
    input wire logic       underflow,
    input wire logic [7:0] ref_count_out
);

    // a held result keeps its payload until transferred
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(slot_out) && $stable(hit) &&
            $stable(needs_read) && $stable(no_free) && $stable(underflow) &&
            $stable(ref_count_out))
        else $error("result changed while stalled");

    // one request at a time: never ready in the cycle after a transfer
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken back to back");

    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && hit |-> ref_count_out != 8'd0 && !no_free && !underflow)
        else $error("hit with zero count or conflicting flags");

    a_no_free_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && no_free |-> slot_out == 5'd0 && ref_count_out == 8'd0 && !needs_read)
        else $error("no_free result carries data");

    a_underflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && underflow |-> ref_count_out == 8'd0 && !hit && !needs_read)
        else $error("underflow result carries a count");

endmodule

bind block_buffer_cache_lru bcl_checker u_bcl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .slot_out      (rsp.slot_out),
    .hit           (rsp.hit),
    .needs_read    (rsp.needs_read),
    .no_free       (rsp.no_free),
    .underflow     (rsp.underflow),
    .ref_count_out (rsp.ref_count_out)
);

`default_nettype wire

@@ bench/tb.sv @@
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = bcl_pkg::SLOT_COUNT_DEF;
    localparam int QUIET_LIMIT  = 5000;
    localparam int TAGS         = 48;
    localparam int RANDOM_ITEMS = 1300;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  device;
        logic [31:0] block_number;
        logic [4:0]  slot_in;
        logic [31:0] now;
    } cache_req_t;

    typedef struct packed {
        cache_req_t    req;
        logic          known;
        bcl_pkg::rsp_t want;
    } plan_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bcl_req_if req_ch ();
    bcl_rsp_if rsp_ch ();

    block_buffer_cache_lru #(
        .SLOT_COUNT (SLOTS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // mirror of the tag store
    logic [7:0]  shadow_dev   [SLOTS];
    logic [31:0] shadow_blk   [SLOTS];
    logic [7:0]  shadow_refs  [SLOTS];
    logic [31:0] shadow_stamp [SLOTS];
    logic        shadow_valid [SLOTS];

    bcl_pkg::rsp_t pending_rsp[$];
    plan_row_t     plan[$];
    bcl_pkg::rsp_t head_rsp;
    int            errors = 0;
    int            quiet  = 0;
    bit            steady = 1'b0;
    logic [31:0]   tick   = '0;
    logic [7:0]    pool_dev [TAGS];
    logic [31:0]   pool_blk [TAGS];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_dev[i]   = '0;
            shadow_blk[i]   = '0;
            shadow_refs[i]  = '0;
            shadow_stamp[i] = '0;
            shadow_valid[i] = 1'b0;
        end
    end

    // Applies one request to the mirror and returns the result it should give.
    function automatic bcl_pkg::rsp_t cache_access(input cache_req_t r);
        bcl_pkg::rsp_t res;
        int            pick;
        bit            found;
        res   = '0;
        pick  = 0;
        found = 1'b0;
        if (r.action == bcl_pkg::ACT_GET)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!found && shadow_dev[i] == r.device && shadow_blk[i] == r.block_number)
                begin
                    found = 1'b1;
                    pick  = i;
                end
            end
            if (found)
            begin
                if (shadow_refs[pick] != bcl_pkg::REF_MAX)
                    shadow_refs[pick] = shadow_refs[pick] + 8'd1;
                res.slot_out      = pick[4:0];
                res.hit           = 1'b1;
                res.needs_read    = !shadow_valid[pick];
                res.ref_count_out = shadow_refs[pick];
                shadow_valid[pick] = 1'b1;
            end
            else
            begin
                // oldest unreferenced slot, strict compare keeps the lowest on a tie
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (shadow_refs[i] == 8'd0 &&
                        (!found || shadow_stamp[i] < shadow_stamp[pick]))
                    begin
                        found = 1'b1;
                        pick  = i;
                    end
                end
                if (!found)
                    res.no_free = 1'b1;
                else
                begin
                    shadow_dev[pick]   = r.device;
                    shadow_blk[pick]   = r.block_number;
                    shadow_refs[pick]  = 8'd1;
                    shadow_valid[pick] = 1'b1;
                    res.slot_out       = pick[4:0];
                    res.needs_read     = 1'b1;
                    res.ref_count_out  = 8'd1;
                end
            end
        end
        else if (int'(r.slot_in) >= SLOTS)
            res.slot_out = r.slot_in;
        else
        begin
            pick         = int'(r.slot_in);
            res.slot_out = r.slot_in;
            if (r.action == bcl_pkg::ACT_PIN)
            begin
                if (shadow_refs[pick] != bcl_pkg::REF_MAX)
                    shadow_refs[pick] = shadow_refs[pick] + 8'd1;
            end
            else if (shadow_refs[pick] == 8'd0)
                res.underflow = 1'b1;
            else
            begin
                shadow_refs[pick] = shadow_refs[pick] - 8'd1;
                if (r.action == bcl_pkg::ACT_RELEASE && shadow_refs[pick] == 8'd0)
                    shadow_stamp[pick] = r.now;
            end
            res.ref_count_out = shadow_refs[pick];
        end
        return res;
    endfunction

    function automatic bcl_pkg::rsp_t typed_rsp(input logic [4:0] s, input logic h,
                                                input logic nr, input logic nf,
                                                input logic uf, input logic [7:0] c);
        return {s, h, nr, nf, uf, c};
    endfunction

    function automatic void add_row(input logic [1:0] act, input logic [7:0] dev,
                                    input logic [31:0] blk, input logic [4:0] s,
                                    input logic [31:0] stamp, input logic known,
                                    input bcl_pkg::rsp_t want);
        plan_row_t row;
        row.req.action       = act;
        row.req.device       = dev;
        row.req.block_number = blk;
        row.req.slot_in      = s;
        row.req.now          = stamp;
        row.known            = known;
        row.want             = want;
        plan.push_back(row);
    endfunction

    // a slot with a non-zero count, searched from a random start; -1 if none
    function automatic int held_slot();
        int start;
        int s;
        start = $urandom_range(SLOTS - 1);
        for (int i = 0; i < SLOTS; i++)
        begin
            s = (start + i) % SLOTS;
            if (shadow_refs[s] != 8'd0)
                return s;
        end
        return -1;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_req(input cache_req_t r, input logic known,
                            input bcl_pkg::rsp_t want);
        bcl_pkg::rsp_t got;
        while (!steady && $urandom_range(99) < 29)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.action       <= r.action;
        req_ch.device       <= r.device;
        req_ch.block_number <= r.block_number;
        req_ch.slot_in      <= r.slot_in;
        req_ch.now          <= r.now;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        got = cache_access(r);
        pending_rsp.push_back(known ? want : got);
        @(negedge clk);
    endtask

    initial
    begin
        cache_req_t r;
        int         issued;
        int         k;
        int         s;
        bit         fill_a;
        bit         fill_b;
        bit         sat_done;

        req_ch.valid        = 1'b0;
        req_ch.action       = bcl_pkg::ACT_GET;
        req_ch.device       = '0;
        req_ch.block_number = '0;
        req_ch.slot_in      = '0;
        req_ch.now          = '0;

        for (int i = 0; i < TAGS; i++)
        begin
            pool_dev[i] = 8'($urandom_range(3));
            pool_blk[i] = $urandom_range(63);
        end
        pool_dev[0] = 8'h00;
        pool_blk[0] = 32'h0000_0000;
        pool_dev[1] = 8'hFF;
        pool_blk[1] = 32'hFFFF_FFFF;

        // every slot starts tagged device 0 block 0, so the first get hits slot 0
        add_row(bcl_pkg::ACT_GET,     8'h00, 32'h0000_0000, 5'd0,  32'h0,
                1'b1, typed_rsp(5'd0, 1'b1, 1'b1, 1'b0, 1'b0, 8'd1));
        add_row(bcl_pkg::ACT_GET,     8'hFF, 32'hFFFF_FFFF, 5'd0,  32'h0,
                1'b1, typed_rsp(5'd1, 1'b0, 1'b1, 1'b0, 1'b0, 8'd1));
        add_row(bcl_pkg::ACT_GET,     8'hFF, 32'hFFFF_FFFF, 5'd0,  32'h0,
                1'b1, typed_rsp(5'd1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd2));
        add_row(bcl_pkg::ACT_RELEASE, 8'h00, 32'h0,         5'd5,  32'h1234,
                1'b1, typed_rsp(5'd5, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0));
        add_row(bcl_pkg::ACT_UNPIN,   8'h00, 32'h0,         5'd31, 32'h0,
                1'b1, typed_rsp(5'd31, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0));
        add_row(bcl_pkg::ACT_PIN,     8'h00, 32'h0,         5'd31, 32'h0,
                1'b1, typed_rsp(5'd31, 1'b0, 1'b0, 1'b0, 1'b0, 8'd1));
        // unpin to zero leaves the stamp alone
        add_row(bcl_pkg::ACT_UNPIN,   8'h00, 32'h0,         5'd31, 32'hFFFF_FFFF,
                1'b1, typed_rsp(5'd31, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        add_row(bcl_pkg::ACT_RELEASE, 8'h00, 32'h0,         5'd0,  32'hFFFF_FFFF,
                1'b1, typed_rsp(5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        add_row(bcl_pkg::ACT_RELEASE, 8'h00, 32'h0,         5'd1,  32'h0,
                1'b1, typed_rsp(5'd1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd1));
        add_row(bcl_pkg::ACT_RELEASE, 8'h00, 32'h0,         5'd1,  32'h0000_55AA,
                1'b1, typed_rsp(5'd1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        add_row(bcl_pkg::ACT_GET,     8'h5A, 32'h1234_5678, 5'd0,  32'h0, 1'b0, '0);
        add_row(bcl_pkg::ACT_GET,     8'h00, 32'h0000_0000, 5'd0,  32'h0, 1'b0, '0);
        add_row(bcl_pkg::ACT_RELEASE, 8'h00, 32'h0,         5'd2,  32'hAAAA_5555, 1'b0, '0);
        add_row(bcl_pkg::ACT_PIN,     8'h00, 32'h0,         5'd2,  32'h0, 1'b0, '0);
        add_row(bcl_pkg::ACT_GET,     8'h5A, 32'h1234_5678, 5'd0,  32'h0, 1'b0, '0);
        add_row(bcl_pkg::ACT_GET,     8'h00, 32'h0000_0001, 5'd0,  32'h0, 1'b0, '0);
        add_row(bcl_pkg::ACT_RELEASE, 8'h00, 32'h0,         5'd3,  32'h0000_0001, 1'b0, '0);
        add_row(bcl_pkg::ACT_UNPIN,   8'h00, 32'h0,         5'd2,  32'h0, 1'b0, '0);
        add_row(bcl_pkg::ACT_UNPIN,   8'h00, 32'h0,         5'd2,  32'h0, 1'b0, '0);
        add_row(bcl_pkg::ACT_UNPIN,   8'h00, 32'h0,         5'd2,  32'h0, 1'b0, '0);
        add_row(bcl_pkg::ACT_GET,     8'hA5, 32'hDEAD_BEEF, 5'd0,  32'h0, 1'b0, '0);
        add_row(bcl_pkg::ACT_PIN,     8'h00, 32'h0,         5'd16, 32'h0, 1'b0, '0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            send_req(plan[i].req, plan[i].known, plan[i].want);

        issued   = 0;
        fill_a   = 1'b0;
        fill_b   = 1'b0;
        sat_done = 1'b0;
        while (issued < RANDOM_ITEMS)
        begin
            steady = (issued >= 300 && issued < 450);
            if ((!fill_a && issued >= 200) || (!fill_b && issued >= 1100))
            begin
                // pin every slot so that a get of a new tag finds nothing free
                if (!fill_a)
                    fill_a = 1'b1;
                else
                    fill_b = 1'b1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    r         = '0;
                    r.action  = bcl_pkg::ACT_PIN;
                    r.slot_in = i[4:0];
                    send_req(r, 1'b0, '0);
                end
                r              = '0;
                r.action       = bcl_pkg::ACT_GET;
                r.device       = 8'($urandom_range(255));
                r.block_number = $urandom;
                send_req(r, 1'b0, '0);
                k              = $urandom_range(TAGS - 1);
                r.device       = pool_dev[k];
                r.block_number = pool_blk[k];
                send_req(r, 1'b0, '0);
                for (int i = 0; i < SLOTS; i++)
                begin
                    r         = '0;
                    r.action  = bcl_pkg::ACT_UNPIN;
                    r.slot_in = i[4:0];
                    send_req(r, 1'b0, '0);
                end
                issued += 2 * SLOTS + 2;
            end
            else if (!sat_done && issued >= 550)
            begin
                // drive one count to the ceiling and back through zero
                sat_done = 1'b1;
                s = $urandom_range(SLOTS - 1);
                for (int i = 0; i < 256; i++)
                begin
                    r         = '0;
                    r.action  = bcl_pkg::ACT_PIN;
                    r.slot_in = s[4:0];
                    send_req(r, 1'b0, '0);
                end
                r              = '0;
                r.action       = bcl_pkg::ACT_GET;
                r.device       = shadow_dev[s];
                r.block_number = shadow_blk[s];
                send_req(r, 1'b0, '0);
                for (int i = 0; i < 260; i++)
                begin
                    r         = '0;
                    r.action  = bcl_pkg::ACT_RELEASE;
                    r.slot_in = s[4:0];
                    r.now     = $urandom;
                    send_req(r, 1'b0, '0);
                end
                issued += 517;
            end
            else
            begin
                r = '0;
                k = $urandom_range(99);
                if (k < 40)
                begin
                    r.action = bcl_pkg::ACT_GET;
                    if ($urandom_range(9) == 0)
                    begin
                        r.device       = 8'($urandom_range(255));
                        r.block_number = $urandom;
                    end
                    else
                    begin
                        s              = $urandom_range(TAGS - 1);
                        r.device       = pool_dev[s];
                        r.block_number = pool_blk[s];
                    end
                end
                else if (k < 65)
                begin
                    r.action  = bcl_pkg::ACT_RELEASE;
                    s         = held_slot();
                    r.slot_in = (s >= 0) ? s[4:0] : 5'($urandom_range(SLOTS - 1));
                    tick      = tick + 32'($urandom_range(1, 40));
                    r.now     = ($urandom_range(9) == 0) ? 32'($urandom) : tick;
                end
                else if (k < 78)
                begin
                    r.action  = bcl_pkg::ACT_PIN;
                    r.slot_in = 5'($urandom_range(SLOTS - 1));
                end
                else if (k < 93)
                begin
                    r.action  = bcl_pkg::ACT_UNPIN;
                    s         = held_slot();
                    if (s >= 0 && $urandom_range(9) < 7)
                        r.slot_in = s[4:0];
                    else
                        r.slot_in = 5'($urandom_range(SLOTS - 1));
                end
                else
                begin
                    r.action       = 2'($urandom_range(3));
                    r.device       = 8'($urandom_range(255));
                    r.block_number = $urandom;
                    r.slot_in      = 5'($urandom_range(31));
                    r.now          = $urandom;
                end
                send_req(r, 1'b0, '0);
                issued++;
            end
        end
        steady       = 1'b0;
        req_ch.valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // result side: random back-pressure plus one long hold-off to fill the block
    initial
    begin
        int rx_cycles;
        int hold_left;
        rx_cycles    = 0;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rx_cycles++;
            if (rx_cycles == 3000)
                hold_left = 400;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= steady || ($urandom_range(99) >= 29);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("unexpected transfer: slot_out %0d ref_count_out %0d",
                       rsp_ch.slot_out, rsp_ch.ref_count_out);
                errors++;
            end
            else
            begin
                head_rsp = pending_rsp.pop_front();
                if (rsp_ch.slot_out !== head_rsp.slot_out)
                begin
                    $error("slot_out: expected %0d, got %0d",
                           head_rsp.slot_out, rsp_ch.slot_out);
                    errors++;
                end
                if (rsp_ch.hit !== head_rsp.hit)
                begin
                    $error("hit: expected %0d, got %0d", head_rsp.hit, rsp_ch.hit);
                    errors++;
                end
                if (rsp_ch.needs_read !== head_rsp.needs_read)
                begin
                    $error("needs_read: expected %0d, got %0d",
                           head_rsp.needs_read, rsp_ch.needs_read);
                    errors++;
                end
                if (rsp_ch.no_free !== head_rsp.no_free)
                begin
                    $error("no_free: expected %0d, got %0d",
                           head_rsp.no_free, rsp_ch.no_free);
                    errors++;
                end
                if (rsp_ch.underflow !== head_rsp.underflow)
                begin
                    $error("underflow: expected %0d, got %0d",
                           head_rsp.underflow, rsp_ch.underflow);
                    errors++;
                end
                if (rsp_ch.ref_count_out !== head_rsp.ref_count_out)
                begin
                    $error("ref_count_out: expected %0d, got %0d",
                           head_rsp.ref_count_out, rsp_ch.ref_count_out);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
        else
            quiet = quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/bcl_pkg.sv
hw/rtl/bcl_if.sv
hw/rtl/bcl_slot_mem.sv
hw/rtl/bcl_ctrl.sv
hw/rtl/block_buffer_cache_lru.sv
hw/rtl/bcl_checker.sv
bench/tb.sv
